// ===== hdl/integer_to_roman_numeral_unit_macros.svh =====
// Assertion macros for the Roman numeral unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef INTEGER_TO_ROMAN_NUMERAL_UNIT_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_UNIT_MACROS_SVH
`ifndef SYNTH
// Check prop at every rising clock edge outside reset.
`define IRN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop at every rising clock edge, reset included.
`define IRN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRN_ASSERT(lbl, clk, rst, prop, msg)
`define IRN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/irn_pkg.sv =====
// Shared types, constants and spelling functions for the Roman numeral unit.
// No dependencies; every other file but the assertion macro header imports it.
`timescale 1ns / 1ps
package irn_pkg;

   localparam int unsigned VALUE_WIDTH  = 12;
   localparam int unsigned SYMBOL_WIDTH = 7;
   localparam int unsigned DIGIT_WIDTH  = 4;
   localparam int unsigned NUM_DIGITS   = 4;
   localparam int unsigned IRN_QUEUE_DEPTH = 2;

   localparam logic [VALUE_WIDTH-1:0] MAX_VALID = 12'd3999;

   localparam logic [SYMBOL_WIDTH-1:0] SYM_NONE = 7'h00;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_I    = 7'h49;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_V    = 7'h56;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_X    = 7'h58;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_L    = 7'h4C;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_C    = 7'h43;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_D    = 7'h44;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_M    = 7'h4D;

   localparam logic [1:0] IDX_ONES      = 2'd0;
   localparam logic [1:0] IDX_TENS      = 2'd1;
   localparam logic [1:0] IDX_HUNDREDS  = 2'd2;
   localparam logic [1:0] IDX_THOUSANDS = 2'd3;

   typedef enum logic [1:0] {
      CLS_UNIT,
      CLS_FIVE,
      CLS_TEN
   } irn_class_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_PUSH
   } irn_front_state_type;

   typedef enum logic {
      B_IDLE,
      B_EMIT
   } irn_back_state_type;

   typedef struct packed {
      logic                                   range_error;
      logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] digits;
   } irn_entry_type;

   typedef struct packed {
      logic          valid;
      irn_entry_type entry;
   } irn_push_type;

   typedef struct packed {
      logic          empty;
      irn_entry_type entry;
   } irn_qstat_type;

   typedef struct packed {
      logic       found;
      logic [1:0] idx;
   } irn_find_type;

   // Number of characters that spell one decimal digit.
   function automatic logic [2:0] digit_len(input logic [DIGIT_WIDTH-1:0] d);
      logic [2:0] len;
      unique case (d)
         4'd1, 4'd5:        len = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:              len = 3'd2;
         4'd3, 4'd7:        len = 3'd3;
         4'd8:              len = 3'd4;
         default:           len = 3'd0;
      endcase
      return len;
   endfunction

   // Which of unit, five or ten stands at position pos of digit d.
   function automatic irn_class_type digit_class(input logic [DIGIT_WIDTH-1:0] d,
                                                 input logic [1:0] pos);
      irn_class_type cls;
      if (d == 4'd9) begin
         cls = (pos == 2'd0) ? CLS_UNIT : CLS_TEN;
      end else if (d == 4'd4) begin
         cls = (pos == 2'd0) ? CLS_UNIT : CLS_FIVE;
      end else if (d >= 4'd5 && pos == 2'd0) begin
         cls = CLS_FIVE;
      end else begin
         cls = CLS_UNIT;
      end
      return cls;
   endfunction

   // ASCII letter for a class at a given decimal place.
   function automatic logic [SYMBOL_WIDTH-1:0] roman_symbol(input logic [1:0] idx,
                                                            input irn_class_type cls);
      logic [SYMBOL_WIDTH-1:0] sym;
      sym = SYM_NONE;
      unique case (idx)
         IDX_ONES:
            sym = (cls == CLS_UNIT) ? SYM_I : (cls == CLS_FIVE) ? SYM_V : SYM_X;
         IDX_TENS:
            sym = (cls == CLS_UNIT) ? SYM_X : (cls == CLS_FIVE) ? SYM_L : SYM_C;
         IDX_HUNDREDS:
            sym = (cls == CLS_UNIT) ? SYM_C : (cls == CLS_FIVE) ? SYM_D : SYM_M;
         default:
            sym = SYM_M;
      endcase
      return sym;
   endfunction

   // Highest nonzero digit strictly below place limit.
   function automatic irn_find_type find_lower(
         input logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] digits,
         input logic [2:0] limit);
      irn_find_type res;
      res = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (3'(i) < limit && digits[i] != '0) begin
            res.found = 1'b1;
            res.idx   = 2'(i);
         end
      end
      return res;
   endfunction

endpackage

// ===== hdl/irn_if.sv =====
// Handshake channels of the Roman numeral unit: request and response.
// Depends on irn_pkg for field widths.
`timescale 1ns / 1ps
interface irn_req_if import irn_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface irn_rsp_if import irn_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SYMBOL_WIDTH-1:0] symbol;
   logic                    last;
   logic                    range_error;

   modport source (output valid, output symbol, output last, output range_error,
                   input ready);
   modport sink   (input valid, input symbol, input last, input range_error,
                   output ready);
endinterface

// ===== hdl/irn_front.sv =====
// Front end: accept a value, range check it, split it into decimal digits.
// Depends on irn_pkg and irn_if.
`timescale 1ns / 1ps
module irn_front import irn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   irn_req_if.sink      req_ch,
   input  logic         queue_full,
   output irn_push_type push
);

   localparam int unsigned BCD_WIDTH = NUM_DIGITS * DIGIT_WIDTH;
   localparam int unsigned CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   irn_front_state_type st_ff, st_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   err_ff, err_in;
   logic                   accept;
   logic                   in_error;
   logic [BCD_WIDTH-1:0]   bcd_adj;

   assign accept   = req_ch.valid && req_ch.ready;
   assign in_error = (req_ch.value == '0) || (req_ch.value > MAX_VALID);

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         F_IDLE: if (accept) st_in = in_error ? F_PUSH : F_CONV;
         F_CONV: if (cnt_ff == CNT_WIDTH'(1)) st_in = F_PUSH;
         F_PUSH: if (!queue_full) st_in = F_IDLE;
         default: st_in = F_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ch.ready            = (st_ff == F_IDLE);
      push.valid              = (st_ff == F_PUSH) && !queue_full;
      push.entry.range_error  = err_ff;
      push.entry.digits       = bcd_ff;
   end

   // Double dabble: add three to every digit of five or more, then shift in a bit
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
            (bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= 4'd5) ?
            bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] + 4'd3 :
            bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH];
      end
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      err_in = err_ff;
      if (accept) begin
         bin_in = req_ch.value;
         bcd_in = '0;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH);
         err_in = in_error;
      end else if (st_ff == F_CONV) begin
         {bcd_in, bin_in} = {bcd_adj[BCD_WIDTH-2:0], bin_ff, 1'b0};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      err_ff <= err_in;
   end

endmodule

// ===== hdl/irn_queue.sv =====
// Short queue of classified items between front and back end.
// Depends on irn_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "integer_to_roman_numeral_unit_macros.svh"
module irn_queue import irn_pkg::*; #(
   parameter int unsigned DEPTH = IRN_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  irn_push_type  push,
   output logic          full,
   input  logic          pop,
   output irn_qstat_type qstat
);

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

   irn_entry_type          slots_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full        = (count_ff == CNT_WIDTH'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign qstat.entry = slots_ff[rd_ptr_ff];
   assign do_push     = push.valid && !full;
   assign do_pop      = pop && !qstat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   `IRN_ASSERT(a_no_push_full, clock, reset, push.valid |-> !full, "push into full queue")
   `IRN_ASSERT(a_no_pop_empty, clock, reset, pop |-> !qstat.empty, "pop from empty queue")
   `IRN_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_WIDTH'(DEPTH), "count overflow")
   `IRN_ASSERT(a_count_up, clock, reset, (do_push && !do_pop) |=>
      (count_ff == $past(count_ff) + CNT_WIDTH'(1)), "count did not advance on push")

endmodule

// ===== hdl/irn_back.sv =====
// Back end: spell each queued item as Roman letters, one per response.
// Depends on irn_pkg, irn_if and the assertion macro header.
`timescale 1ns / 1ps
`include "integer_to_roman_numeral_unit_macros.svh"
module irn_back import irn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  irn_qstat_type qstat,
   output logic          pop,
   irn_rsp_if.source     rsp_ch
);

   irn_back_state_type       st_ff, st_in;
   irn_entry_type            entry_ff;
   logic [1:0]               idx_ff;
   logic [1:0]               pos_ff;
   logic                     rsp_valid_ff;
   logic [SYMBOL_WIDTH-1:0]  sym_ff;
   logic                     last_ff;
   logic                     err_ff;

   logic [DIGIT_WIDTH-1:0]   cur_d;
   logic                     pos_more;
   irn_find_type             lower;
   irn_find_type             start;
   logic                     char_last;
   logic [SYMBOL_WIDTH-1:0]  char_sym;
   logic                     slot_free;
   logic                     emit;
   logic                     load;

   assign cur_d     = entry_ff.digits[idx_ff];
   assign pos_more  = ({1'b0, pos_ff} + 3'd1) < digit_len(cur_d);
   assign lower     = find_lower(entry_ff.digits, {1'b0, idx_ff});
   assign start     = find_lower(qstat.entry.digits, 3'(NUM_DIGITS));
   assign char_last = entry_ff.range_error || (!pos_more && !lower.found);
   assign char_sym  = entry_ff.range_error ? SYM_NONE :
                      roman_symbol(idx_ff, digit_class(cur_d, pos_ff));
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         B_IDLE: if (!qstat.empty) st_in = B_EMIT;
         B_EMIT: if (slot_free && char_last) st_in = B_IDLE;
         default: st_in = B_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      load = (st_ff == B_IDLE) && !qstat.empty;
      emit = (st_ff == B_EMIT) && slot_free;
      pop  = load;
      rsp_ch.valid       = rsp_valid_ff;
      rsp_ch.symbol      = sym_ff;
      rsp_ch.last        = last_ff;
      rsp_ch.range_error = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Cursor: digit place and position within its pattern
   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= qstat.entry;
         idx_ff   <= start.idx;
         pos_ff   <= 2'd0;
      end else if (emit) begin
         if (pos_more) begin
            pos_ff <= pos_ff + 2'd1;
         end else begin
            idx_ff <= lower.idx;
            pos_ff <= 2'd0;
         end
      end
      if (emit) begin
         sym_ff  <= char_sym;
         last_ff <= char_last;
         err_ff  <= entry_ff.range_error;
      end
   end

   `IRN_ASSERT(a_err_shape, clock, reset, (rsp_valid_ff && err_ff) |->
      (last_ff && sym_ff == SYM_NONE), "error response must be a single empty symbol")
   `IRN_ASSERT(a_ok_letter, clock, reset, (rsp_valid_ff && !err_ff) |->
      (sym_ff != SYM_NONE), "valid response without a letter")
   `IRN_ASSERT(a_cursor_digit, clock, reset, (st_ff == B_EMIT && !entry_ff.range_error) |->
      (cur_d != '0), "cursor on a zero digit")

endmodule

// ===== hdl/integer_to_roman_numeral_unit.sv =====
// Top level of the Roman numeral unit: front end, item queue, back end.
// Depends on irn_pkg, irn_if, irn_front, irn_queue and irn_back.
//
// Converts a 12-bit unsigned value into its Roman numeral, one ASCII letter per
// response, most significant first, with last set on the final letter. Values 0
// and above 3999 give one response with symbol 0, last 1 and range_error 1.
// The front end takes a value and splits it into decimal digits with a
// shift-and-add-three converter, then queues it (error values skip the
// converter). The back end pulls one item from the queue, then sends one letter
// per cycle while the receiver takes them, 1 to 15 letters. Front and back work
// on separate items, so at sustained load the back end's one-letter-per-cycle
// output register sets the rate for long numerals and the digit converter for
// short ones.
`timescale 1ns / 1ps
module integer_to_roman_numeral_unit import irn_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = IRN_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   irn_req_if.sink   req_ch,
   irn_rsp_if.source rsp_ch
);

   irn_push_type  push;
   irn_qstat_type qstat;
   logic          queue_full;
   logic          pop;

   // Accept, range check and convert to decimal digits
   irn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   // Hold converted items so front and back stall independently
   irn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .qstat (qstat)
   );

   // Spell digits as letters and drive the response register
   irn_back u_back (
      .clock  (clock),
      .reset  (reset),
      .qstat  (qstat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
